FILE: hw/rtl/rthsv_pkg.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter shared definitions
// Stage counts, hue sector codes and the beat types that flow between the
// front end, the pipelined divider and the output stage.
// ----------------------------------------------------------------------------
package rthsv_pkg;

    localparam int DIV_X_W            = 24;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = DIV_X_W / DIV_BITS_PER_STAGE;
    localparam int FRONT_STAGES       = 2;
    localparam int PIPE_STAGES        = FRONT_STAGES + DIV_STAGES + 1;

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    localparam logic [16:0] HUE_GREEN_OFFSET = 17'd15360;
    localparam logic [16:0] HUE_BLUE_OFFSET  = 17'd30720;
    localparam logic [16:0] HUE_FULL         = 17'd46080;

    typedef struct packed {
        logic [DIV_X_W-1:0] x;
        logic [7:0]         d;
        logic [7:0]         rem;
        logic [DIV_X_W-1:0] q;
    } div_lane_t;

    typedef struct packed {
        logic [1:0] sector;
        logic       neg;
        logic       gray;
        logic [7:0] value;
    } div_side_t;

    typedef struct packed {
        div_lane_t sat;
        div_lane_t hue;
        div_side_t side;
    } div_word_t;

endpackage

FILE: hw/rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Converts one packed 24-bit RGB pixel per beat into fixed-point hue,
// saturation and value through a fifteen-stage pipeline.
//
//   Channel   Handshake                    Payload
//   pixel     pixel_valid / pixel_stall    pixel_rgb[23:0]
//   result    result_valid / result_stall  hue[15:0], saturation[16:0], value[7:0]
//
// One pixel per cycle is accepted while pixel_stall is low.
// The depth comes from the divider, which yields two quotient bits per stage
// over a 24-bit dividend, after two front-end stages and one output stage.
// Reset clears only the per-stage valid bits.
// Each stage holding a bubble still takes a beat while result_stall is high.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [23:0] pixel_rgb,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] hue,
    output logic [16:0] saturation,
    output logic [7:0]  value
);
    import rthsv_pkg::*;

    logic [PIPE_STAGES-1:0] vld_reg;
    logic [PIPE_STAGES-1:0] vld_next;
    logic [PIPE_STAGES-1:0] src_valid;
    logic [PIPE_STAGES-1:0] rdy;
    logic [PIPE_STAGES-1:0] en;
    div_word_t              front_word;
    div_word_t              div_word;

    always_comb
    begin
        src_valid = {vld_reg[PIPE_STAGES-2:0], pixel_valid};
        rdy[PIPE_STAGES-1] = !vld_reg[PIPE_STAGES-1] || !result_stall;
        for (int i = PIPE_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
        en       = rdy & src_valid;
        vld_next = (rdy & src_valid) | (~rdy & vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    rthsv_front u_front (
        .clk       (clk),
        .en        (en[FRONT_STAGES-1:0]),
        .pixel_rgb (pixel_rgb),
        .word_out  (front_word)
    );

    rthsv_div u_div (
        .clk      (clk),
        .en       (en[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
        .word_in  (front_word),
        .word_out (div_word)
    );

    rthsv_back u_back (
        .clk        (clk),
        .en         (en[PIPE_STAGES-1]),
        .word_in    (div_word),
        .hue        (hue),
        .saturation (saturation),
        .value      (value)
    );

    assign pixel_stall  = !rdy[0];
    assign result_valid = vld_reg[PIPE_STAGES-1];

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (&vld_reg))
        else $error("input stalled while the pipeline has an empty stage");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (hue < 16'd46080))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (saturation <= 17'd65536))
        else $error("saturation out of range");

    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (saturation == 17'd0)) |-> (hue == 16'd0))
        else $error("gray pixel with nonzero hue");

endmodule

FILE: hw/rtl/rthsv_front.sv
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two register stages: channel maximum, max-min delta, hue sector and difference, then the
// scaled hue difference and the dividend and divisor of both divisions.
// ----------------------------------------------------------------------------
module rthsv_front (
    input  logic                                        clk,
    input  logic [rthsv_pkg::FRONT_STAGES-1:0]          en,
    input  logic [23:0]                                 pixel_rgb,
    output rthsv_pkg::div_word_t                        word_out
);
    import rthsv_pkg::*;

    logic [7:0]       r;
    logic [7:0]       g;
    logic [7:0]       b;
    logic [7:0]       hi_next;
    logic [7:0]       lo_next;
    logic [1:0]       sector_next;
    logic signed [8:0] diff_next;

    logic [7:0]       hi_reg;
    logic [7:0]       delta_reg;
    logic [1:0]       sector_reg;
    logic signed [8:0] diff_reg;

    logic             neg;
    logic [8:0]       abs_wide;
    logic [7:0]       abs_diff;
    logic [11:0]      scaled;
    div_word_t        word_next;
    div_word_t        word_reg;

    always_comb
    begin
        r = pixel_rgb[23:16];
        g = pixel_rgb[15:8];
        b = pixel_rgb[7:0];
        hi_next = (r > g) ? r : g;
        if (b > hi_next)
        begin
            hi_next = b;
        end
        lo_next = (r < g) ? r : g;
        if (b < lo_next)
        begin
            lo_next = b;
        end
        if (r >= hi_next)
        begin
            sector_next = SECT_RED;
            diff_next   = $signed({1'b0, g}) - $signed({1'b0, b});
        end
        else if (g >= hi_next)
        begin
            sector_next = SECT_GREEN;
            diff_next   = $signed({1'b0, b}) - $signed({1'b0, r});
        end
        else
        begin
            sector_next = SECT_BLUE;
            diff_next   = $signed({1'b0, r}) - $signed({1'b0, g});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hi_reg     <= hi_next;
            delta_reg  <= hi_next - lo_next;
            sector_reg <= sector_next;
            diff_reg   <= diff_next;
        end
    end

    // The hue term is |diff| * 7680 / delta, and 7680 is 15 * 512.
    always_comb
    begin
        neg      = diff_reg[8];
        abs_wide = neg ? 9'(-diff_reg) : 9'(diff_reg);
        abs_diff = abs_wide[7:0];
        scaled   = {abs_diff, 4'b0000} - {4'b0000, abs_diff};

        word_next             = '0;
        word_next.sat.x       = {delta_reg, 16'h0000};
        word_next.sat.d       = hi_reg;
        word_next.hue.x       = {3'b000, scaled, 9'h000};
        word_next.hue.d       = delta_reg;
        word_next.side.sector = sector_reg;
        word_next.side.neg    = neg;
        word_next.side.gray   = (delta_reg == 8'd0);
        word_next.side.value  = hi_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

FILE: hw/rtl/rthsv_div.sv
// ----------------------------------------------------------------------------
// RGB to HSV pipelined divider
// Restoring division of the saturation and hue dividends, two quotient bits
// per register stage, with the pixel sideband carried alongside.
// ----------------------------------------------------------------------------
module rthsv_div (
    input  logic                                clk,
    input  logic [rthsv_pkg::DIV_STAGES-1:0]    en,
    input  rthsv_pkg::div_word_t                word_in,
    output rthsv_pkg::div_word_t                word_out
);
    import rthsv_pkg::*;

    div_word_t stage_reg  [DIV_STAGES];
    div_word_t stage_next [DIV_STAGES];

    function automatic div_lane_t lane_step(input div_lane_t a);
        div_lane_t  o;
        logic [8:0] trial;
        o = a;
        for (int i = 0; i < DIV_BITS_PER_STAGE; i++)
        begin
            trial = {o.rem, o.x[DIV_X_W-1]};
            o.x   = {o.x[DIV_X_W-2:0], 1'b0};
            if (trial >= {1'b0, o.d})
            begin
                o.rem = 8'(trial - {1'b0, o.d});
                o.q   = {o.q[DIV_X_W-2:0], 1'b1};
            end
            else
            begin
                o.rem = trial[7:0];
                o.q   = {o.q[DIV_X_W-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        div_word_t src;

        if (k == 0)
        begin : g_first
            assign src = word_in;
        end
        else
        begin : g_rest
            assign src = stage_reg[k-1];
        end

        always_comb
        begin
            stage_next[k].sat  = lane_step(src.sat);
            stage_next[k].hue  = lane_step(src.hue);
            stage_next[k].side = src.side;
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign word_out = stage_reg[DIV_STAGES-1];

endmodule

FILE: hw/rtl/rthsv_back.sv
// ----------------------------------------------------------------------------
// RGB to HSV output stage
// Applies sign and sector offset to the hue quotient, wraps negative hues,
// clears hue and saturation of gray pixels and holds the result beat.
// ----------------------------------------------------------------------------
module rthsv_back (
    input  logic                    clk,
    input  logic                    en,
    input  rthsv_pkg::div_word_t    word_in,
    output logic [15:0]             hue,
    output logic [16:0]             saturation,
    output logic [7:0]              value
);
    import rthsv_pkg::*;

    logic [12:0]        term;
    logic signed [16:0] term_s;
    logic [16:0]        offset;
    logic signed [16:0] sum;
    logic signed [16:0] wrapped;
    logic [15:0]        hue_next;
    logic [16:0]        sat_next;

    logic [15:0]        hue_reg;
    logic [16:0]        sat_reg;
    logic [7:0]         value_reg;

    always_comb
    begin
        term = word_in.hue.q[12:0];
        term_s = word_in.side.neg ? -$signed({4'b0000, term}) : $signed({4'b0000, term});
        case (word_in.side.sector)
            SECT_GREEN: offset = HUE_GREEN_OFFSET;
            SECT_BLUE:  offset = HUE_BLUE_OFFSET;
            default:    offset = 17'd0;
        endcase
        sum = $signed(offset) + term_s;
        wrapped = sum[16] ? (sum + $signed(HUE_FULL)) : sum;
        if (word_in.side.gray)
        begin
            hue_next = 16'd0;
            sat_next = 17'd0;
        end
        else
        begin
            hue_next = wrapped[15:0];
            sat_next = word_in.sat.q[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            value_reg <= word_in.side.value;
        end
    end

    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign value      = value_reg;

endmodule

FILE: verif/rgb_to_hsv_converter_test.sv
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Drives packed RGB pixels into the converter and checks every hue,
// saturation and value beat against a behavioral fixed-point conversion.
// The run covers corner pixels, random pixels under random idling on both
// sides, back-to-back bursts and a long output hold that fills the pipeline.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import rthsv_pkg::*;

    localparam int HUE_SIXTH   = 7680;
    localparam int SAT_ONE     = 65536;
    localparam int DRAIN_WAIT  = PIPE_STAGES + 8;

    typedef struct packed {
        logic [15:0] hue;
        logic [16:0] sat;
        logic [7:0]  val;
    } hsv_t;

    logic        clk;
    logic        rst_n;
    logic        pixel_valid;
    logic        pixel_stall;
    logic [23:0] pixel_rgb;
    logic        result_valid;
    logic        result_stall;
    logic [15:0] hue;
    logic [16:0] saturation;
    logic [7:0]  value;

    hsv_t expected_hsv[$];
    int   error_count;
    int   pixels_sent;
    int   results_checked;
    int   input_stall_cycles;
    bit   burst_mode;
    bit   stall_enable;
    int   hold_left;

    rgb_to_hsv_converter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel_rgb    (pixel_rgb),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .hue          (hue),
        .saturation   (saturation),
        .value        (value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic hsv_t convert_pixel(input logic [23:0] px);
        int   r;
        int   g;
        int   b;
        int   hi;
        int   lo;
        int   delta;
        int   h;
        int   s;
        hsv_t res;
        r = int'(px[23:16]);
        g = int'(px[15:8]);
        b = int'(px[7:0]);
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        delta = hi - lo;
        h = 0;
        s = 0;
        if (delta > 0)
        begin
            s = (delta * SAT_ONE) / hi;
            if (r >= hi)
                h = ((g - b) * HUE_SIXTH) / delta;
            else if (g >= hi)
                h = int'(HUE_GREEN_OFFSET) + ((b - r) * HUE_SIXTH) / delta;
            else
                h = int'(HUE_BLUE_OFFSET) + ((r - g) * HUE_SIXTH) / delta;
            if (h < 0)
                h = h + int'(HUE_FULL);
        end
        res.hue = h[15:0];
        res.sat = s[16:0];
        res.val = hi[7:0];
        return res;
    endfunction

    function automatic logic [23:0] random_pixel();
        logic [7:0] a;
        logic [7:0] c;
        int         kind;
        a = 8'($urandom_range(0, 255));
        c = 8'($urandom_range(0, 255));
        kind = $urandom_range(0, 9);
        case (kind)
            0: return {a, a, a};
            1: return {a, a, c};
            2: return {c, a, a};
            3: return {a, c, a};
            4: return {a, a ^ 8'd1, a - 8'd1};
            5: return {8'hFF, a, c};
            default: return 24'($urandom_range(0, 24'hFFFFFF));
        endcase
    endfunction

    function automatic int pick_gap();
        int roll;
        if (burst_mode)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_pixel(input logic [23:0] px);
        bit taken;
        int gap;
        pixel_valid <= 1'b1;
        pixel_rgb   <= px;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !pixel_stall;
            if (taken)
                expected_hsv.push_back(convert_pixel(px));
            else
                input_stall_cycles++;
            @(posedge clk);
        end
        pixels_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Receiver side: random stall runs, or a forced hold when one is requested.
    initial
    begin
        int  run_left;
        bit  stalling;
        result_stall = 1'b0;
        run_left = 0;
        stalling = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (!stall_enable)
            begin
                result_stall <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stalling = ($urandom_range(0, 99) < 30);
                    if (!stalling)
                        run_left = $urandom_range(1, 20);
                    else if ($urandom_range(0, 9) == 0)
                        run_left = $urandom_range(10, 40);
                    else
                        run_left = $urandom_range(1, 3);
                end
                result_stall <= stalling;
                run_left--;
            end
        end
    end

    initial
    begin
        hsv_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (expected_hsv.size() == 0)
                begin
                    error_count++;
                    $display("%0t: result beat with nothing pending: %s %0d %0d %0d",
                             $time, "hue sat val", hue, saturation, value);
                end
                else
                begin
                    want = expected_hsv.pop_front();
                    results_checked++;
                    if (hue !== want.hue || saturation !== want.sat || value !== want.val)
                    begin
                        error_count++;
                        $display("%0t: mismatch: expected hue %0d sat %0d val %0d,",
                                 $time, want.hue, want.sat, want.val);
                        $display("    got hue %0d sat %0d val %0d",
                                 hue, saturation, value);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        logic [23:0] corner[$];
        corner = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
                   24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
                   24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF00FE,
                   24'hFFFF80, 24'h80FFFF, 24'hFF80FF, 24'h010000,
                   24'h000001, 24'h000100, 24'h020101, 24'h807F7F,
                   24'hFEFFFF, 24'h7F0080, 24'hAA55AA, 24'h0100FF};
        stall_enable = 1'b0;
        foreach (corner[i])
            send_pixel(corner[i]);
    endtask

    task automatic test_random(input int count);
        stall_enable = 1'b1;
        burst_mode = 1'b0;
        repeat (count)
            send_pixel(random_pixel());
    endtask

    task automatic test_burst(input int count);
        stall_enable = 1'b0;
        burst_mode = 1'b1;
        repeat (count)
            send_pixel(random_pixel());
        burst_mode = 1'b0;
    endtask

    task automatic test_backpressure();
        burst_mode = 1'b1;
        hold_left = 200;
        repeat (70)
            send_pixel(random_pixel());
        burst_mode = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel_rgb = '0;
        error_count = 0;
        pixels_sent = 0;
        results_checked = 0;
        input_stall_cycles = 0;
        burst_mode = 1'b0;
        stall_enable = 1'b0;
        hold_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(500);
        test_burst(150);
        test_backpressure();
        test_random(360);

        pixel_valid <= 1'b0;
        stall_enable = 1'b0;
        while (expected_hsv.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Converted %0d pixels and checked %0d result beats.",
                 pixels_sent, results_checked);
        $display("Input side was held off for %0d cycles by output back-pressure.",
                 input_stall_cycles);
        if (error_count == 0)
            $display("rgb_to_hsv_converter_test: done, clean");
        else
            $display("rgb_to_hsv_converter_test: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Run timed out with %0d results outstanding.", expected_hsv.size());
        $display("rgb_to_hsv_converter_test: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rthsv_pkg.sv
hw/rtl/rthsv_front.sv
hw/rtl/rthsv_div.sv
hw/rtl/rthsv_back.sv
hw/rtl/rgb_to_hsv_converter.sv
verif/rgb_to_hsv_converter_test.sv
